### rtl/qadm_pkg.sv
package qadm_pkg;

  localparam int NUM_CLASSES_DEF = 4;

  localparam int CLASS_W    = 2;
  localparam int OP_W       = 2;
  localparam int CONN_W     = 16;
  localparam int BYTE_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CONN_W-1:0] CONN_LIMIT_RST = 16'd1024;
  localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = 32'd1048576;

  // register map: connection limits first, then byte limits
  localparam logic [CFG_IDX_W-1:0] REG_CONN_LIMIT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT0 = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT         = 2'd0,
    OP_RELEASE       = 2'd1,
    OP_RESERVE       = 2'd2,
    OP_RELEASE_BYTES = 2'd3
  } op_t;

  typedef struct packed {
    logic              granted;
    logic [CONN_W-1:0] conn;
    logic [BYTE_W-1:0] bytes;
    logic              saturated;
  } calc_res_t;

endpackage

### rtl/qadm_req_if.sv
interface qadm_req_if;
  logic                           valid;
  logic                           ready;
  logic [qadm_pkg::OP_W-1:0]      req_type;
  logic [qadm_pkg::CLASS_W-1:0]   traffic_class;
  logic [qadm_pkg::BYTE_W-1:0]    byte_amount;

  modport source (output valid, output req_type, output traffic_class, output byte_amount,
                  input ready);
  modport sink   (input valid, input req_type, input traffic_class, input byte_amount,
                  output ready);
endinterface

### rtl/qadm_res_if.sv
interface qadm_res_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [qadm_pkg::CONN_W-1:0] open_connections;
  logic [qadm_pkg::BYTE_W-1:0] reserved_bytes;
  logic                        saturated;

  modport source (output valid, output granted, output open_connections,
                  output reserved_bytes, output saturated, input ready);
  modport sink   (input valid, input granted, input open_connections,
                  input reserved_bytes, input saturated, output ready);
endinterface

### rtl/qadm_cfg_if.sv
interface qadm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [qadm_pkg::CFG_IDX_W-1:0]  index;
  logic [qadm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/qadm_calc.sv
module qadm_calc (
  input  qadm_pkg::op_t                op,
  input  logic [qadm_pkg::BYTE_W-1:0]  amount,
  input  logic [qadm_pkg::CONN_W-1:0]  conn,
  input  logic [qadm_pkg::BYTE_W-1:0]  bytes,
  input  logic [qadm_pkg::CONN_W-1:0]  conn_limit,
  input  logic [qadm_pkg::BYTE_W-1:0]  byte_limit,
  output qadm_pkg::calc_res_t          res
);

  logic [qadm_pkg::CONN_W-1:0] conn_next;
  logic [qadm_pkg::BYTE_W-1:0] bytes_next;
  logic [qadm_pkg::BYTE_W-1:0] headroom;
  logic                        granted;

  assign headroom = byte_limit - bytes;

  always_comb begin
    conn_next  = conn;
    bytes_next = bytes;
    granted    = 1'b1;
    case (op)
      qadm_pkg::OP_ADMIT: begin
        if (conn >= conn_limit) begin
          granted = 1'b0;
        end else begin
          conn_next = conn + 16'd1;
        end
      end
      qadm_pkg::OP_RELEASE: begin
        if (conn != '0) begin
          conn_next = conn - 16'd1;
        end
      end
      qadm_pkg::OP_RESERVE: begin
        // deny when already over a lowered limit or when the sum would overshoot
        if (bytes > byte_limit || amount > headroom) begin
          granted = 1'b0;
        end else begin
          bytes_next = bytes + amount;
        end
      end
      default: begin
        if (amount >= bytes) begin
          bytes_next = '0;
        end else begin
          bytes_next = bytes - amount;
        end
      end
    endcase
  end

  assign res.granted   = granted;
  assign res.conn      = conn_next;
  assign res.bytes     = bytes_next;
  assign res.saturated = (conn_next >= conn_limit) || (bytes_next >= byte_limit);

endmodule

### rtl/per_class_quota_admission_top.sv
// Per-class quota admission: one request beat per cycle is taken into an input register,
// checked and applied against its class counters, and its result is held in an output
// register, which follows the input register on the result path, and the block
// sustains one request per cycle while the result side keeps up. The per-class connection
// and byte counters clear at reset; limits reset to 1024 connections and 1048576 bytes.
// Limit writes on cfg are always accepted and must be made while no request is in flight.
// Requests naming a class at or above NUM_CLASSES change nothing and return all zeros.
module per_class_quota_admission_top #(
  parameter int NUM_CLASSES = qadm_pkg::NUM_CLASSES_DEF
) (
  input logic              clk,
  input logic              rst,
  qadm_req_if.sink         req,
  qadm_res_if.source       res,
  qadm_cfg_if.sink         cfg
);

  localparam logic [qadm_pkg::CLASS_W:0] ClassEnd = (qadm_pkg::CLASS_W + 1)'(NUM_CLASSES);

  logic [qadm_pkg::CONN_W-1:0] conn_limit [NUM_CLASSES];
  logic [qadm_pkg::BYTE_W-1:0] byte_limit [NUM_CLASSES];
  logic [qadm_pkg::CONN_W-1:0] conn_cnt   [NUM_CLASSES];
  logic [qadm_pkg::BYTE_W-1:0] byte_cnt   [NUM_CLASSES];

  // input register
  logic                          in_valid;
  qadm_pkg::op_t                 in_op;
  logic [qadm_pkg::CLASS_W-1:0]  in_cls;
  logic [qadm_pkg::BYTE_W-1:0]   in_amt;

  // result register
  logic                          out_valid;
  logic                          out_granted;
  logic [qadm_pkg::CONN_W-1:0]   out_conn;
  logic [qadm_pkg::BYTE_W-1:0]   out_bytes;
  logic                          out_sat;

  logic                          advance;
  logic                          cls_ok;
  logic [qadm_pkg::CONN_W-1:0]   sel_conn;
  logic [qadm_pkg::BYTE_W-1:0]   sel_bytes;
  logic [qadm_pkg::CONN_W-1:0]   sel_conn_limit;
  logic [qadm_pkg::BYTE_W-1:0]   sel_byte_limit;
  qadm_pkg::calc_res_t           calc;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;
  assign cls_ok    = {1'b0, in_cls} < ClassEnd;

  always_comb begin
    sel_conn       = '0;
    sel_bytes      = '0;
    sel_conn_limit = '0;
    sel_byte_limit = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (in_cls == qadm_pkg::CLASS_W'(c)) begin
        sel_conn       = conn_cnt[c];
        sel_bytes      = byte_cnt[c];
        sel_conn_limit = conn_limit[c];
        sel_byte_limit = byte_limit[c];
      end
    end
  end

  qadm_calc u_calc (
    .op         (in_op),
    .amount     (in_amt),
    .conn       (sel_conn),
    .bytes      (sel_bytes),
    .conn_limit (sel_conn_limit),
    .byte_limit (sel_byte_limit),
    .res        (calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_op  <= qadm_pkg::op_t'(req.req_type);
      in_cls <= req.traffic_class;
      in_amt <= req.byte_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (cls_ok) begin
        out_granted <= calc.granted;
        out_conn    <= calc.conn;
        out_bytes   <= calc.bytes;
        out_sat     <= calc.saturated;
      end else begin
        out_granted <= 1'b0;
        out_conn    <= '0;
        out_bytes   <= '0;
        out_sat     <= 1'b0;
      end
    end
  end

  // class counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        conn_cnt[c] <= '0;
        byte_cnt[c] <= '0;
      end
    end else if (advance && cls_ok) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (in_cls == qadm_pkg::CLASS_W'(c)) begin
          conn_cnt[c] <= calc.conn;
          byte_cnt[c] <= calc.bytes;
        end
      end
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        conn_limit[c] <= qadm_pkg::CONN_LIMIT_RST;
        byte_limit[c] <= qadm_pkg::BYTE_LIMIT_RST;
      end
    end else if (cfg.valid) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cfg.index == qadm_pkg::REG_CONN_LIMIT0 + qadm_pkg::CFG_IDX_W'(c)) begin
          conn_limit[c] <= cfg.data[qadm_pkg::CONN_W-1:0];
        end
        if (cfg.index == qadm_pkg::REG_BYTE_LIMIT0 + qadm_pkg::CFG_IDX_W'(c)) begin
          byte_limit[c] <= cfg.data[qadm_pkg::BYTE_W-1:0];
        end
      end
    end
  end

  assign res.valid            = out_valid;
  assign res.granted          = out_granted;
  assign res.open_connections = out_conn;
  assign res.reserved_bytes   = out_bytes;
  assign res.saturated        = out_sat;

endmodule
